>>> src/hanoi_move_generator_assert.svh
// Assertion macros for the Tower of Hanoi move generator.
`ifndef HANOI_MOVE_GENERATOR_ASSERT_SVH
`define HANOI_MOVE_GENERATOR_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define HMG_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define HMG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HMG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/hmg_pkg.sv
// Shared types, constants and helpers of the Tower of Hanoi move generator.
package hmg_pkg;

	localparam int MAX_RINGS   = 16;
	localparam int NUM_TOWERS  = 3;
	localparam int RING_W      = 5;
	localparam int TOWER_W     = 2;
	localparam int CNT_W       = 16;
	localparam int IDX_W       = $clog2(MAX_RINGS);
	localparam int MEM_DEPTH   = NUM_TOWERS * (2 ** IDX_W);
	localparam int RESET_RINGS = 3;

	typedef logic [TOWER_W-1:0] tower_t;
	typedef logic [RING_W-1:0]  ring_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	localparam tower_t TWR_A = 2'd0;
	localparam tower_t TWR_B = 2'd1;
	localparam tower_t TWR_C = 2'd2;

	// Neighbour one step up, modulo three.
	function automatic tower_t tower_inc(input tower_t t);
		return (t == TWR_C) ? TWR_A : tower_t'(t + 2'd1);
	endfunction

	// Neighbour two steps up, modulo three.
	function automatic tower_t tower_dec(input tower_t t);
		return (t == TWR_A) ? TWR_C : tower_t'(t - 2'd1);
	endfunction

	// Ring count as used by the puzzle: 0 reads as 1, above the maximum saturates.
	function automatic ring_t clamp_count(input ring_t v);
		if (v == ring_t'(0))
			return ring_t'(1);
		if (v > ring_t'(MAX_RINGS))
			return ring_t'(MAX_RINGS);
		return v;
	endfunction

endpackage

>>> src/hanoi_move_generator.sv
// Tower of Hanoi move generator: top level with stack memory and move logic.

// Produces the optimal move sequence that carries ring_count rings (1..16) from
// tower A to tower B, one move per request. A request with restart=1 reloads the
// start position (latching the ring_count register) and returns finished=1; a
// request with restart=0 returns the next move, or finished=1 once all rings sit
// on tower B. The block takes one request per clock cycle and each result appears
// in the output register the cycle after its request; a stalled result holds the
// request channel only while the output register is full and stalled. The top and
// second ring of each tower live in registers, the rings below them in a
// single-port-write synchronous RAM; popping a tower reads the next ring down,
// which is registered out of the RAM and bypassed into the move logic if the same
// tower is used again at once. After reset or restart tower A's RAM contents are
// implied by a low-water mark, so there is no clearing pass. ring_count is only
// picked up at reset and at restart.
`include "hanoi_move_generator_assert.svh"

module hanoi_move_generator (
	input  logic                  clk,
	input  logic                  arst_n,
	// ring_count register write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [4:0]            cfg_data,
	// request channel
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  restart,
	// result channel
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [15:0]           move_number,
	output logic [4:0]            ring,
	output logic [1:0]            from_tower,
	output logic [1:0]            to_tower,
	output logic                  last,
	output logic                  finished
);

	// ring_count register and count latched into the running puzzle
	hmg_pkg::ring_t  cfg_q;
	hmg_pkg::ring_t  n_q;

	// per-tower top, second-from-top and height
	hmg_pkg::ring_t  top_q [hmg_pkg::NUM_TOWERS];
	hmg_pkg::ring_t  sec_q [hmg_pkg::NUM_TOWERS];
	hmg_pkg::ring_t  hgt_q [hmg_pkg::NUM_TOWERS];

	// next move prepared at the end of the previous one
	hmg_pkg::tower_t src_q;
	hmg_pkg::tower_t dst_q;
	hmg_pkg::ring_t  mring_q;
	hmg_pkg::cnt_t   cnt_q;

	// lowest RAM slot of tower A written since the last load
	hmg_pkg::idx_t   lw_q;

	// refill of a popped tower's second slot in flight
	logic            pend_q;
	hmg_pkg::tower_t pend_twr_q;
	hmg_pkg::ring_t  rd_q;

	// rings below the cached top two, addressed {tower, slot}
	hmg_pkg::ring_t  stack_mem [hmg_pkg::MEM_DEPTH];

	// result register
	logic            res_valid_q;
	hmg_pkg::cnt_t   move_number_q;
	hmg_pkg::ring_t  ring_q;
	hmg_pkg::tower_t from_tower_q;
	hmg_pkg::tower_t to_tower_q;
	logic            last_q;
	logic            finished_q;

	// combinational move logic
	logic            accept;
	logic            done;
	logic            do_move;
	hmg_pkg::ring_t  sec_eff [hmg_pkg::NUM_TOWERS];
	hmg_pkg::ring_t  ntop    [hmg_pkg::NUM_TOWERS];
	hmg_pkg::ring_t  nsec    [hmg_pkg::NUM_TOWERS];
	hmg_pkg::ring_t  nhgt    [hmg_pkg::NUM_TOWERS];
	hmg_pkg::ring_t  top_src;
	hmg_pkg::tower_t ta;
	hmg_pkg::tower_t tb;
	hmg_pkg::tower_t nsrc;
	hmg_pkg::tower_t na;
	hmg_pkg::tower_t nb;
	hmg_pkg::tower_t ndst;
	logic            last_c;
	hmg_pkg::cnt_t   cnt_inc;
	hmg_pkg::ring_t  ld_n;
	hmg_pkg::ring_t  ld_base;

	// RAM access
	hmg_pkg::ring_t  dst_hm2;
	hmg_pkg::ring_t  src_hm3;
	logic            wr_en;
	hmg_pkg::idx_t   wr_idx;
	hmg_pkg::ring_t  wr_data;
	logic            rd_en;
	hmg_pkg::idx_t   rd_idx;
	logic            rd_init;
	hmg_pkg::ring_t  rd_init_val;

	// ------------------------------------------------------------------
	// Handshakes: the result register drains in the same cycle it refills.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;
	assign req_stall = res_valid_q && res_stall;
	assign accept    = req_valid && !req_stall;

	assign done    = (hgt_q[hmg_pkg::TWR_B] == hmg_pkg::ring_t'(n_q + 5'd1));
	assign do_move = accept && !restart && !done;
	assign cnt_inc = hmg_pkg::cnt_t'(cnt_q + 16'd1);

	assign ld_n    = hmg_pkg::clamp_count(cfg_q);
	assign ld_base = hmg_pkg::ring_t'(ld_n + 5'd1);

	// ------------------------------------------------------------------
	// Second slot with bypass of the refill read issued last cycle.
	// ------------------------------------------------------------------
	always_comb begin
		for (int t = 0; t < hmg_pkg::NUM_TOWERS; t++) begin
			if (pend_q && (pend_twr_q == hmg_pkg::tower_t'(t)))
				sec_eff[t] = rd_q;
			else
				sec_eff[t] = sec_q[t];
		end
	end

	assign top_src = top_q[src_q];

	// ------------------------------------------------------------------
	// Apply the move: pop src, push onto dst.
	// ------------------------------------------------------------------
	always_comb begin
		for (int t = 0; t < hmg_pkg::NUM_TOWERS; t++) begin
			ntop[t] = top_q[t];
			nsec[t] = sec_eff[t];
			nhgt[t] = hgt_q[t];
			if (src_q == hmg_pkg::tower_t'(t)) begin
				ntop[t] = sec_eff[t];
				nhgt[t] = hmg_pkg::ring_t'(hgt_q[t] - 5'd1);
			end
			if (dst_q == hmg_pkg::tower_t'(t)) begin
				ntop[t] = top_src;
				nsec[t] = top_q[t];
				nhgt[t] = hmg_pkg::ring_t'(hgt_q[t] + 5'd1);
			end
		end
	end

	assign last_c = (nhgt[hmg_pkg::TWR_B] == hmg_pkg::ring_t'(n_q + 5'd1));

	// Next source: the smaller top of the two towers not just targeted.
	assign ta   = hmg_pkg::tower_inc(dst_q);
	assign tb   = hmg_pkg::tower_dec(dst_q);
	assign nsrc = (ntop[ta] < ntop[tb]) ? ta : tb;

	// Next target: odd counts turn one way round the towers, even the other.
	assign na = hmg_pkg::tower_inc(nsrc);
	assign nb = hmg_pkg::tower_dec(nsrc);
	always_comb begin
		if (n_q[0])
			ndst = (ntop[nsrc] < ntop[na]) ? na : nb;
		else
			ndst = (ntop[nsrc] < ntop[nb]) ? nb : na;
	end

	// ------------------------------------------------------------------
	// RAM: a push spills dst's old second ring; a pop refills src's second.
	// ------------------------------------------------------------------
	assign dst_hm2 = hmg_pkg::ring_t'(hgt_q[dst_q] - 5'd2);
	assign src_hm3 = hmg_pkg::ring_t'(hgt_q[src_q] - 5'd3);

	assign wr_en   = do_move && (hgt_q[dst_q] >= 5'd2);
	assign wr_idx  = dst_hm2[hmg_pkg::IDX_W-1:0];
	assign wr_data = sec_eff[dst_q];

	assign rd_en   = do_move && (hgt_q[src_q] >= 5'd3);
	assign rd_idx  = src_hm3[hmg_pkg::IDX_W-1:0];

	// Tower A below the low-water mark still holds its loaded rings.
	assign rd_init     = (src_q == hmg_pkg::TWR_A) && (rd_idx < lw_q);
	assign rd_init_val = hmg_pkg::ring_t'(n_q + 5'd1 - hmg_pkg::ring_t'(rd_idx));

	always_ff @(posedge clk) begin
		if (wr_en)
			stack_mem[{dst_q, wr_idx}] <= wr_data;
		if (rd_en)
			rd_q <= rd_init ? rd_init_val : stack_mem[{src_q, rd_idx}];
	end

	// ------------------------------------------------------------------
	// Puzzle state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= hmg_pkg::ring_t'(hmg_pkg::RESET_RINGS);
			n_q        <= hmg_pkg::ring_t'(hmg_pkg::RESET_RINGS);
			for (int t = 0; t < hmg_pkg::NUM_TOWERS; t++) begin
				if (hmg_pkg::tower_t'(t) == hmg_pkg::TWR_A) begin
					top_q[t] <= hmg_pkg::ring_t'(1);
					sec_q[t] <= hmg_pkg::ring_t'(2);
					hgt_q[t] <= hmg_pkg::ring_t'(hmg_pkg::RESET_RINGS + 1);
				end else begin
					top_q[t] <= hmg_pkg::ring_t'(hmg_pkg::RESET_RINGS + 1);
					sec_q[t] <= hmg_pkg::ring_t'(hmg_pkg::RESET_RINGS + 1);
					hgt_q[t] <= hmg_pkg::ring_t'(1);
				end
			end
			src_q      <= hmg_pkg::TWR_A;
			dst_q      <= (hmg_pkg::RESET_RINGS % 2 == 1) ? hmg_pkg::TWR_B : hmg_pkg::TWR_C;
			mring_q    <= hmg_pkg::ring_t'(1);
			cnt_q      <= '0;
			lw_q       <= '1;
			pend_q     <= 1'b0;
			pend_twr_q <= hmg_pkg::TWR_A;
		end else begin
			if (cfg_valid && cfg_ready)
				cfg_q <= cfg_data;

			pend_q     <= rd_en;
			pend_twr_q <= src_q;

			if (accept && restart) begin
				n_q <= ld_n;
				for (int t = 0; t < hmg_pkg::NUM_TOWERS; t++) begin
					if (hmg_pkg::tower_t'(t) == hmg_pkg::TWR_A) begin
						top_q[t] <= hmg_pkg::ring_t'(1);
						sec_q[t] <= hmg_pkg::ring_t'(2);
						hgt_q[t] <= ld_base;
					end else begin
						top_q[t] <= ld_base;
						sec_q[t] <= ld_base;
						hgt_q[t] <= hmg_pkg::ring_t'(1);
					end
				end
				src_q   <= hmg_pkg::TWR_A;
				dst_q   <= ld_n[0] ? hmg_pkg::TWR_B : hmg_pkg::TWR_C;
				mring_q <= hmg_pkg::ring_t'(1);
				cnt_q   <= '0;
				lw_q    <= '1;
			end else if (do_move) begin
				for (int t = 0; t < hmg_pkg::NUM_TOWERS; t++) begin
					top_q[t] <= ntop[t];
					sec_q[t] <= nsec[t];
					hgt_q[t] <= nhgt[t];
				end
				src_q   <= nsrc;
				dst_q   <= ndst;
				mring_q <= ntop[nsrc];
				cnt_q   <= cnt_inc;
				if (wr_en && (dst_q == hmg_pkg::TWR_A) && (wr_idx < lw_q))
					lw_q <= wr_idx;
			end else begin
				// no move: fold a landed refill into its register
				for (int t = 0; t < hmg_pkg::NUM_TOWERS; t++)
					sec_q[t] <= sec_eff[t];
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			move_number_q <= do_move ? cnt_inc : '0;
			ring_q        <= do_move ? mring_q : '0;
			from_tower_q  <= do_move ? src_q : hmg_pkg::TWR_A;
			to_tower_q    <= do_move ? dst_q : hmg_pkg::TWR_A;
			last_q        <= do_move && last_c;
			finished_q    <= !do_move;
		end
	end

	assign res_valid   = res_valid_q;
	assign move_number = move_number_q;
	assign ring        = ring_q;
	assign from_tower  = from_tower_q;
	assign to_tower    = to_tower_q;
	assign last        = last_q;
	assign finished    = finished_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	// every ring plus the three base markers is on some tower
	`HMG_ASSERT_ALWAYS(a_height_sum, (7'(hgt_q[0]) + 7'(hgt_q[1]) + 7'(hgt_q[2])) == (7'(n_q) + 7'd3), "tower heights do not add up to the ring count")
	// a refill only targets a tower that still has a second slot
	`HMG_ASSERT_IMP(a_refill_height, pend_q, hgt_q[pend_twr_q] >= 5'd2, "refill landed on a tower with no second slot")
	// each move advances the move counter by one
	`HMG_ASSERT_NEXT(a_count_step, do_move, cnt_q == hmg_pkg::cnt_t'($past(cnt_q) + 16'd1), "move counter did not advance")
	// a restart request yields a finished result
	`HMG_ASSERT_NEXT(a_restart_result, accept && restart, res_valid && finished && (move_number == 16'd0), "restart did not report finished")

endmodule
